// ===== hw/rtl/lfia_pkg.sv =====
// ----------------------------------------------------------------------------
// lfia_pkg
// Shared types and constants for the lowest-free ID allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

  // Default size of the ID space
  localparam int ID_COUNT_DEF = 16;

  // Field widths of the event and result transfers
  localparam int FUNC_W   = 2;
  localparam int EVID_W   = 5;
  localparam int SYS_W    = 8;
  localparam int OUTID_W  = 4;

  // Event kinds
  localparam logic [FUNC_W-1:0] FUNC_CONNECT    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DISCONNECT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE     = 2'd2;

  // Outcome of an allocation search
  typedef struct packed {
    logic from_map;   // lowest freed ID taken from the bitmap
    logic from_next;  // highest seen plus one handed out
    logic exhausted;  // nothing left
  } pick_stat_t;

endpackage

// ===== hw/rtl/lfia_in_if.sv =====
// ----------------------------------------------------------------------------
// lfia_in_if
// Event channel: valid/ready handshake with the device event payload.
// ----------------------------------------------------------------------------
interface lfia_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [lfia_pkg::FUNC_W-1:0]    func;
  logic signed [lfia_pkg::EVID_W-1:0]    dev_id;
  logic signed [lfia_pkg::EVID_W-1:0]    previous_id;
  logic        [lfia_pkg::SYS_W-1:0]     system_ref;

  modport source (output valid, func, dev_id, previous_id, system_ref, input ready);
  modport sink   (input valid, func, dev_id, previous_id, system_ref, output ready);
endinterface

// ===== hw/rtl/lfia_out_if.sv =====
// ----------------------------------------------------------------------------
// lfia_out_if
// Result channel: valid/ready handshake with the ID assignment payload.
// ----------------------------------------------------------------------------
interface lfia_out_if;
  logic                              valid;
  logic                              ready;
  logic [lfia_pkg::OUTID_W-1:0]      assigned_id;
  logic [lfia_pkg::SYS_W-1:0]        system_out;
  logic                              exhausted;

  modport source (output valid, assigned_id, system_out, exhausted, input ready);
  modport sink   (input valid, assigned_id, system_out, exhausted, output ready);
endinterface

// ===== hw/rtl/lfia_pick.sv =====
// ----------------------------------------------------------------------------
// lfia_pick
// Allocation search: lowest freed ID, else highest seen plus one.
// ----------------------------------------------------------------------------
module lfia_pick #(
  parameter int ID_COUNT = lfia_pkg::ID_COUNT_DEF,
  parameter int IDW      = $clog2(ID_COUNT),
  parameter int HSW      = IDW + 1
) (
  input  logic [ID_COUNT-1:0]     map,
  input  logic signed [HSW-1:0]   highest,
  output logic [ID_COUNT-1:0]     low_onehot,
  output logic signed [HSW-1:0]   next_high,
  output logic [IDW-1:0]          pick_id,
  output lfia_pkg::pick_stat_t    stat
);

  logic [IDW-1:0] enc;
  logic           any_free;
  logic           room;

  // isolate lowest set bit
  assign low_onehot = map & (~map + ID_COUNT'(1));
  assign any_free   = |map;
  assign next_high  = highest + HSW'(1);
  assign room       = (int'(highest) + 1) < ID_COUNT;

  always_comb begin
    enc = '0;
    for (int i = 0; i < ID_COUNT; i++) begin
      if (low_onehot[i]) begin
        enc = enc | IDW'(i);
      end
    end
  end

  always_comb begin
    stat.from_map  = any_free;
    stat.from_next = !any_free && room;
    stat.exhausted = !any_free && !room;
    pick_id        = any_free ? enc : IDW'(next_high);
  end

endmodule

// ===== hw/rtl/lowest_free_id_allocator.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Device ID allocator handing out the lowest freed ID first.
// ----------------------------------------------------------------------------
// Events enter an input register and are resolved from that register by a
// short search over the freed-ID bitmap, which updates the bitmap and the
// highest-seen register and loads the result register in the same edge. One
// event is taken per cycle unless stalled; a connect event without an ID has
// its result loaded into the result register as it leaves the input register.
// Only such an event can stall: it waits in the input register while the
// result register holds a transfer not yet taken, and the event channel's
// ready then drops. All other events never produce a result and always move
// on. The single input and single result registers set that rate.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator #(
  parameter int ID_COUNT = lfia_pkg::ID_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  lfia_in_if.sink        evt,
  lfia_out_if.source     res
);

  localparam int IDW = $clog2(ID_COUNT);
  localparam int HSW = IDW + 1;   // signed, holds -1 .. ID_COUNT-1

  // Input register
  logic                                   q_valid;
  logic [lfia_pkg::FUNC_W-1:0]            q_func;
  logic signed [lfia_pkg::EVID_W-1:0]     q_dev;
  logic signed [lfia_pkg::EVID_W-1:0]     q_prev;
  logic [lfia_pkg::SYS_W-1:0]             q_sys;

  // Allocator state
  logic [ID_COUNT-1:0]                    freed_map;
  logic [ID_COUNT-1:0]                    freed_map_next;
  logic signed [HSW-1:0]                  highest_seen;
  logic signed [HSW-1:0]                  highest_seen_next;

  // Result register
  logic                                   r_valid;
  logic [lfia_pkg::OUTID_W-1:0]           r_id;
  logic [lfia_pkg::SYS_W-1:0]             r_sys;
  logic                                   r_exh;

  // Search results
  logic [ID_COUNT-1:0]                    low_onehot;
  logic signed [HSW-1:0]                  next_high;
  logic [IDW-1:0]                         pick_id;
  lfia_pkg::pick_stat_t                   stat;

  // Control
  logic                                   produces;
  logic                                   advance;
  logic                                   dev_ok;
  logic                                   prev_ok;
  logic [ID_COUNT-1:0]                    dev_mask;
  logic [ID_COUNT-1:0]                    prev_mask;
  logic                                   raise;
  logic signed [HSW-1:0]                  dev_hs;

  lfia_pick #(
    .ID_COUNT (ID_COUNT),
    .IDW      (IDW),
    .HSW      (HSW)
  ) u_pick (
    .map        (freed_map),
    .highest    (highest_seen),
    .low_onehot (low_onehot),
    .next_high  (next_high),
    .pick_id    (pick_id),
    .stat       (stat)
  );

  // Only a connect event without an ID yields a result transfer
  assign produces  = (q_func == lfia_pkg::FUNC_CONNECT) && q_dev[lfia_pkg::EVID_W-1];
  assign advance   = q_valid && (!produces || !r_valid || res.ready);
  assign evt.ready = !q_valid || advance;

  // Negative IDs mean none; IDs past the range are ignored
  assign dev_ok    = !q_dev[lfia_pkg::EVID_W-1] && (int'(q_dev[3:0]) < ID_COUNT);
  assign prev_ok   = !q_prev[lfia_pkg::EVID_W-1] && (int'(q_prev[3:0]) < ID_COUNT);
  assign dev_mask  = dev_ok  ? (ID_COUNT'(1) << q_dev[3:0])  : '0;
  assign prev_mask = prev_ok ? (ID_COUNT'(1) << q_prev[3:0]) : '0;
  assign dev_hs    = HSW'({1'b0, q_dev[3:0]});
  assign raise     = dev_ok && (int'(q_dev[3:0]) > int'(highest_seen));

  always_comb begin
    freed_map_next    = freed_map;
    highest_seen_next = highest_seen;
    case (q_func)
      lfia_pkg::FUNC_CONNECT: begin
        if (!q_dev[lfia_pkg::EVID_W-1]) begin
          // claim the carried ID
          freed_map_next = freed_map & ~dev_mask;
          if (raise) begin
            highest_seen_next = dev_hs;
          end
        end else if (stat.from_map) begin
          freed_map_next = freed_map & ~low_onehot;
        end else if (stat.from_next) begin
          highest_seen_next = next_high;
        end
      end
      lfia_pkg::FUNC_DISCONNECT: begin
        freed_map_next = freed_map | dev_mask;
      end
      lfia_pkg::FUNC_UPDATE: begin
        // claim first, then free: equal IDs end up freed
        freed_map_next = (freed_map & ~dev_mask) | prev_mask;
        if (raise) begin
          highest_seen_next = dev_hs;
        end
      end
      default: begin
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (evt.ready) begin
      q_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      q_func <= evt.func;
      q_dev  <= evt.dev_id;
      q_prev <= evt.previous_id;
      q_sys  <= evt.system_ref;
    end
  end

  // Allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      freed_map    <= '0;
      highest_seen <= '1;
    end else if (advance) begin
      freed_map    <= freed_map_next;
      highest_seen <= highest_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance && produces) begin
      r_valid <= 1'b1;
    end else if (res.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      r_id  <= stat.exhausted ? '0 : lfia_pkg::OUTID_W'(pick_id);
      r_sys <= q_sys;
      r_exh <= stat.exhausted;
    end
  end

  assign res.valid       = r_valid;
  assign res.assigned_id = r_id;
  assign res.system_out  = r_sys;
  assign res.exhausted   = r_exh;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_high_range : assert property (@(posedge clk) disable iff (rst)
    (int'(highest_seen) >= -1) && (int'(highest_seen) < ID_COUNT))
    else $error("highest_seen out of range");

  a_exh_zero : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.exhausted) |-> (res.assigned_id == '0))
    else $error("exhausted result carries a non-zero ID");

  a_exh_cause : assert property (@(posedge clk) disable iff (rst)
    (advance && produces) |=>
      (res.exhausted == (($past(freed_map) == '0) &&
                         (int'($past(highest_seen)) == ID_COUNT - 1))))
    else $error("exhaustion flag disagrees with allocator state");

  a_map_clear : assert property (@(posedge clk) disable iff (rst)
    (advance && produces && stat.from_map) |=> ((freed_map & $past(low_onehot)) == '0))
    else $error("allocated ID still marked free");

  a_hold_item : assert property (@(posedge clk) disable iff (rst)
    (q_valid && !advance) |=> q_valid)
    else $error("stalled event lost from input register");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lowest-free ID allocator.
// ----------------------------------------------------------------------------
// Device events go in through the event channel, and ID grants come out on the
// result channel. The bench runs its own copy of the freed-ID bitmap and the
// highest-seen register, and works out the grant that each connect without an
// ID should receive. Each grant taken from the block is checked against the
// oldest grant still owed. A directed opening covers the corner cases. A
// random run then follows, in fill, churn and drain phases, so that
// exhaustion and reuse of freed IDs both come up often. Both channels idle
// in random bursts, and the result side holds off for long stretches so that
// the block backs up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_COUNT    = lfia_pkg::ID_COUNT_DEF;
  localparam int RAND_EVENTS = 1660;   // counted events in the random run
  localparam int CALM_TAIL   = 300;    // last events run with no idling
  localparam int LONG_HOLD   = 300;    // cycles of a long result-side hold-off
  localparam int STALL_LIMIT = 4000;   // cycles with no transfer before giving up
  localparam int TAIL_CYCLES = 8;      // settle time once nothing is owed

  // func 3 is not a defined event kind
  localparam logic [lfia_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [lfia_pkg::EVID_W-1:0] NO_ID    = -5'sd1;
  localparam logic signed [lfia_pkg::EVID_W-1:0] MOST_NEG = 5'b10000;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_CHURN,
    MODE_DRAIN
  } load_mode_t;

  typedef struct packed {
    logic [lfia_pkg::OUTID_W-1:0] id;
    logic [lfia_pkg::SYS_W-1:0]   sys;
    logic                         exhausted;
  } id_grant_t;

  // --------------------------------------------------------------------------
  // Ledger of IDs: mirrors the allocator state and holds the grants still owed
  // --------------------------------------------------------------------------
  class grant_ledger_t;
    logic [ID_COUNT-1:0] freed_ids;
    int                  top_id;
    id_grant_t           grants_due[$];
    int                  errors;

    function new();
      freed_ids = '0;
      top_id    = -1;
      errors    = 0;
    endfunction

    // only the first ten problems get a line of their own
    function void complain(string msg);
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch: %s", $time, msg);
    endfunction

    function void claim(int id);
      if (id < 0 || id >= ID_COUNT)
        return;
      if (id > top_id)
        top_id = id;
      freed_ids[id] = 1'b0;
    endfunction

    function void free_id(int id);
      if (id < 0 || id >= ID_COUNT)
        return;
      freed_ids[id] = 1'b1;
    endfunction

    function void note_event(logic [lfia_pkg::FUNC_W-1:0] f,
                             logic signed [lfia_pkg::EVID_W-1:0] d,
                             logic signed [lfia_pkg::EVID_W-1:0] p,
                             logic [lfia_pkg::SYS_W-1:0] s);
      id_grant_t g;
      int        slot;
      slot = -1;
      case (f)
        lfia_pkg::FUNC_CONNECT: begin
          if (d >= 0) begin
            claim(int'(d));
          end else begin
            // lowest freed ID first, then a fresh one above the highest seen
            if (freed_ids != '0) begin
              for (int i = ID_COUNT - 1; i >= 0; i--)
                if (freed_ids[i])
                  slot = i;
              freed_ids[slot] = 1'b0;
            end else if (top_id + 1 < ID_COUNT) begin
              top_id++;
              slot = top_id;
            end
            g.sys       = s;
            g.exhausted = (slot < 0);
            g.id        = (slot < 0) ? '0 : slot[lfia_pkg::OUTID_W-1:0];
            grants_due.push_back(g);
          end
        end
        lfia_pkg::FUNC_DISCONNECT: free_id(int'(d));
        lfia_pkg::FUNC_UPDATE: begin
          // claim before free: equal IDs end up freed
          claim(int'(d));
          free_id(int'(p));
        end
        default: ;
      endcase
    endfunction

    function void check_grant(id_grant_t got);
      id_grant_t want;
      if (grants_due.size() == 0) begin
        complain($sformatf("unexpected grant id %0d sys %0d exhausted %0b",
                           got.id, got.sys, got.exhausted));
        return;
      end
      want = grants_due.pop_front();
      if (got.id !== want.id || got.sys !== want.sys ||
          got.exhausted !== want.exhausted)
        complain($sformatf("grant id %0d/%0d sys %0d/%0d exhausted %0b/%0b (exp/act)",
                           want.id, got.id, want.sys, got.sys,
                           want.exhausted, got.exhausted));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  lfia_in_if  evt ();
  lfia_out_if res ();

  lowest_free_id_allocator #(
    .ID_COUNT (ID_COUNT)
  ) dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res)
  );

  grant_ledger_t ledger = new();

  bit calm      = 1'b0;   // no idling on either side
  bit long_hold = 1'b0;   // request a long hold-off on the result side

  // --------------------------------------------------------------------------
  // Event side
  // --------------------------------------------------------------------------
  // Idle burst before an event; valid drops only here, never in the step
  // where the next event is raised.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_event(input logic [lfia_pkg::FUNC_W-1:0] f,
                            input logic signed [lfia_pkg::EVID_W-1:0] d,
                            input logic signed [lfia_pkg::EVID_W-1:0] p,
                            input logic [lfia_pkg::SYS_W-1:0] s);
    sender_gap();
    evt.valid       <= 1'b1;
    evt.func        <= f;
    evt.dev_id      <= d;
    evt.previous_id <= p;
    evt.system_ref  <= s;
    // the transfer happens at the first edge that sees ready high
    do @(posedge clk); while (evt.ready !== 1'b1);
    ledger.note_event(f, d, p, s);
  endtask

  function automatic logic signed [lfia_pkg::EVID_W-1:0] any_none();
    // mostly -1, otherwise any negative code
    if ($urandom_range(0, 1) == 0)
      return NO_ID;
    return lfia_pkg::EVID_W'($urandom_range(16, 31));
  endfunction

  function automatic logic signed [lfia_pkg::EVID_W-1:0] any_id();
    return lfia_pkg::EVID_W'($urandom_range(0, ID_COUNT - 1));
  endfunction

  // One random event, shaped by the current load mode.
  // Returns 0 for events the block simply ignores.
  task automatic random_event(input load_mode_t mode, output bit counted);
    int                                 w_conn, w_claim, w_disc, w_upd, r;
    logic signed [lfia_pkg::EVID_W-1:0] d, p;
    logic [lfia_pkg::SYS_W-1:0]         s;
    case (mode)
      MODE_FILL:  begin w_conn = 65; w_claim = 8;  w_disc = 12; w_upd = 10; end
      MODE_CHURN: begin w_conn = 40; w_claim = 10; w_disc = 27; w_upd = 18; end
      default:    begin w_conn = 15; w_claim = 5;  w_disc = 55; w_upd = 20; end
    endcase
    r       = $urandom_range(0, 99);
    s       = lfia_pkg::SYS_W'($urandom);
    p       = lfia_pkg::EVID_W'($urandom_range(0, 31));   // don't-care unless updating
    counted = 1'b1;
    if (r < w_conn) begin
      send_event(lfia_pkg::FUNC_CONNECT, any_none(), p, s);
    end else if (r < w_conn + w_claim) begin
      send_event(lfia_pkg::FUNC_CONNECT, any_id(), p, s);
    end else if (r < w_conn + w_claim + w_disc) begin
      d = ($urandom_range(0, 9) == 0) ? any_none() : any_id();
      counted = (d >= 0);
      send_event(lfia_pkg::FUNC_DISCONNECT, d, p, s);
    end else if (r < w_conn + w_claim + w_disc + w_upd) begin
      d = ($urandom_range(0, 6) == 0) ? any_none() : any_id();
      case ($urandom_range(0, 9))
        0, 1:    p = any_none();
        2:       p = d;
        default: p = any_id();
      endcase
      counted = (d >= 0) || (p >= 0);
      send_event(lfia_pkg::FUNC_UPDATE, d, p, s);
    end else begin
      counted = 1'b0;
      send_event(FUNC_UNUSED, lfia_pkg::EVID_W'($urandom_range(0, 31)), p, s);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready bursts, plus long hold-offs on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    res.ready <= 1'b0;
    forever begin
      if (long_hold) begin
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // grants are checked at the edge of their transfer
  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1)
      ledger.check_grant(id_grant_t'{res.assigned_id, res.system_out, res.exhausted});
  end

  // Watchdog: too long with no transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (evt.valid && evt.ready) || (res.valid && res.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    load_mode_t mode;
    bit         counted;
    int         done;
    evt.valid       <= 1'b0;
    evt.func        <= lfia_pkg::FUNC_CONNECT;
    evt.dev_id      <= NO_ID;
    evt.previous_id <= NO_ID;
    evt.system_ref  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: fresh IDs, reuse, claims, exhaustion, odd frees
    send_event(lfia_pkg::FUNC_CONNECT,    NO_ID,    5'sd15,   8'h00);  // -> 0
    send_event(lfia_pkg::FUNC_CONNECT,    MOST_NEG, MOST_NEG, 8'hFF);  // any negative is none -> 1
    send_event(lfia_pkg::FUNC_CONNECT,    -5'sd5,   5'sd0,    8'hA5);  // -> 2
    send_event(lfia_pkg::FUNC_DISCONNECT, 5'sd1,    NO_ID,    8'h11);
    send_event(lfia_pkg::FUNC_DISCONNECT, NO_ID,    5'sd3,    8'h22);  // nothing to free
    send_event(lfia_pkg::FUNC_CONNECT,    NO_ID,    NO_ID,    8'h5A);  // lowest freed -> 1
    send_event(lfia_pkg::FUNC_CONNECT,    5'sd15,   NO_ID,    8'h33);  // claim top ID
    send_event(lfia_pkg::FUNC_CONNECT,    NO_ID,    NO_ID,    8'h3C);  // exhausted
    send_event(FUNC_UNUSED,               5'sd0,    5'sd0,    8'h44);  // ignored kind
    send_event(lfia_pkg::FUNC_DISCONNECT, 5'sd7,    NO_ID,    8'h55);  // never handed out
    send_event(lfia_pkg::FUNC_DISCONNECT, 5'sd7,    NO_ID,    8'h66);  // already free
    send_event(lfia_pkg::FUNC_UPDATE,     5'sd4,    5'sd4,    8'h77);  // same ID: ends freed
    send_event(lfia_pkg::FUNC_UPDATE,     5'sd9,    NO_ID,    8'h88);
    send_event(lfia_pkg::FUNC_UPDATE,     NO_ID,    5'sd0,    8'h99);  // only the free
    send_event(lfia_pkg::FUNC_CONNECT,    NO_ID,    NO_ID,    8'hC3);  // -> 0
    send_event(lfia_pkg::FUNC_CONNECT,    NO_ID,    NO_ID,    8'h0F);  // -> 4
    send_event(lfia_pkg::FUNC_CONNECT,    NO_ID,    NO_ID,    8'hF0);  // -> 7
    send_event(lfia_pkg::FUNC_CONNECT,    NO_ID,    NO_ID,    8'h81);  // exhausted again
    send_event(lfia_pkg::FUNC_DISCONNECT, 5'sd15,   MOST_NEG, 8'h7E);
    send_event(lfia_pkg::FUNC_CONNECT,    MOST_NEG, 5'sd15,   8'h42);  // top ID reused -> 15
    send_event(FUNC_UNUSED,               5'sd15,   MOST_NEG, 8'hFF);

    // Random run in phases; long hold-offs make the block back up
    done = 0;
    mode = MODE_FILL;
    while (done < RAND_EVENTS) begin
      if (done % 64 == 0)
        mode = load_mode_t'($urandom_range(0, 2));
      if (done == 500 || done == 1200)
        long_hold = 1'b1;
      calm = (done >= RAND_EVENTS - CALM_TAIL);
      random_event(mode, counted);
      if (counted)
        done++;
    end
    evt.valid <= 1'b0;

    // drain: the watchdog covers a grant that never comes
    while (ledger.grants_due.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (ledger.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
